[hdl/fl64_pkg.sv]
// Shared types and constants for the Fletcher-64 word checksum block.
package fl64_pkg;

  localparam int unsigned MaxWords = 65536;
  localparam int unsigned PosW     = $clog2(MaxWords);
  localparam int unsigned IdxW     = 16;
  localparam int unsigned WordW    = 32;
  localparam int unsigned CsumW    = 2 * WordW;
  localparam int unsigned CfgDataW = IdxW;
  localparam int unsigned CfgAddrW = 1;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_CHECKSUM_INDEX = 1'b0,
    CFG_INSERT_MODE    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [IdxW-1:0] checksum_index;
    logic            insert_mode;
  } cfg_t;

  typedef struct packed {
    logic [CsumW-1:0] checksum_value;
    logic             match;
  } res_t;

endpackage

[hdl/fl64_if.sv]
// Handshake channels for input words and checksum results.
interface fl64_word_if;
  logic                          valid;
  logic                          ready;
  logic [fl64_pkg::WordW-1:0]    data_word;
  logic                          last_word;

  modport source (output valid, output data_word, output last_word, input ready);
  modport sink   (input valid, input data_word, input last_word, output ready);
endinterface

interface fl64_csum_if;
  logic                          valid;
  logic                          ready;
  logic [fl64_pkg::CsumW-1:0]    checksum_value;
  logic                          match;

  modport source (output valid, output checksum_value, output match, input ready);
  modport sink   (input valid, input checksum_value, input match, output ready);
endinterface

[hdl/fletcher64_word_checksum.sv]
// Top level of the Fletcher-64 word checksum with result output and skid stage.
//
//  channel   dir  fields                         accepted when
//  word_i    in   data_word[31:0], last_word     valid & ready
//  csum_o    out  checksum_value[63:0], match    valid & ready
//  cfg_*     in   cfg_index_i, cfg_wdata_i[15:0] cfg_we_i
//
// One word per cycle while ready is high; the sums update in the cycle a word is accepted.
// A result is registered into the output register, or the skid entry if the output is held.
// Output register plus one skid entry: words keep flowing while a result waits;
// ready drops only when both result slots are full.
// Asynchronous active-low reset clears sums, position, config registers and valids.
module fletcher64_word_checksum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fl64_word_if.sink                     word_i,
  fl64_csum_if.source                   csum_o,
  input  logic                          cfg_we_i,
  input  logic [fl64_pkg::CfgAddrW-1:0] cfg_index_i,
  input  logic [fl64_pkg::CfgDataW-1:0] cfg_wdata_i
);

  fl64_pkg::cfg_t cfg_q, cfg_d;
  fl64_pkg::res_t res, out_q, out_d, skid_q, skid_d;
  logic           res_valid;
  logic           out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic           acc, out_pop;

  assign word_i.ready = !skid_valid_q;
  assign acc          = word_i.valid & word_i.ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (fl64_pkg::cfg_reg_e'(cfg_index_i))
        fl64_pkg::CFG_CHECKSUM_INDEX: cfg_d.checksum_index = cfg_wdata_i;
        fl64_pkg::CFG_INSERT_MODE:    cfg_d.insert_mode    = cfg_wdata_i[0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  fl64_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .word_i      (word_i.data_word),
    .last_i      (word_i.last_word),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_pop = out_valid_q & csum_o.ready;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q && out_pop) begin
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end else if (res_valid) begin
      if (!out_valid_q || out_pop) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      cfg_q        <= cfg_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign csum_o.valid          = out_valid_q;
  assign csum_o.checksum_value = out_q.checksum_value;
  assign csum_o.match          = out_q.match;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_last_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && word_i.last_word |=> out_valid_q)
    else $error("last word did not produce a result");

  a_skid_drains_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_pop |=> out_valid_q && !skid_valid_q)
    else $error("skid entry not moved to output");

endmodule

[hdl/fl64_core.sv]
// Running sums, word position and stored checksum capture for one range.
module fl64_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       acc_i,
  input  logic [fl64_pkg::WordW-1:0] word_i,
  input  logic                       last_i,
  input  fl64_pkg::cfg_t             cfg_i,
  output logic                       res_valid_o,
  output fl64_pkg::res_t             res_o
);

  localparam int unsigned CmpW =
    ((fl64_pkg::PosW > fl64_pkg::IdxW) ? fl64_pkg::PosW : fl64_pkg::IdxW) + 1;

  logic [fl64_pkg::WordW-1:0] low_q, low_d;
  logic [fl64_pkg::WordW-1:0] high_q, high_d;
  logic [fl64_pkg::PosW-1:0]  pos_q, pos_d;
  logic [fl64_pkg::CsumW-1:0] stored_q, stored_d;

  logic [fl64_pkg::WordW-1:0] low_nxt, high_nxt;
  logic [fl64_pkg::CsumW-1:0] stored_nxt, csum;
  logic [CmpW-1:0]            pos_ext, idx_ext;
  logic                       first_slot, second_slot;

  assign pos_ext     = CmpW'(pos_q);
  assign idx_ext     = CmpW'(cfg_i.checksum_index);
  assign first_slot  = (pos_ext == idx_ext);
  // compared one bit wider, so an index at the top never wraps onto position zero
  assign second_slot = (pos_ext == idx_ext + CmpW'(1));

  always_comb begin
    stored_nxt = stored_q;
    low_nxt    = low_q;
    if (first_slot) begin
      stored_nxt[fl64_pkg::WordW-1:0] = word_i;
    end else if (second_slot) begin
      stored_nxt[fl64_pkg::CsumW-1:fl64_pkg::WordW] = word_i;
    end else begin
      low_nxt = low_q + word_i;
    end
    high_nxt = high_q + low_nxt;
    csum     = {high_nxt, low_nxt};
  end

  assign res_valid_o          = acc_i & last_i;
  assign res_o.checksum_value = csum;
  assign res_o.match          = cfg_i.insert_mode | (stored_nxt == csum);

  always_comb begin
    low_d    = low_q;
    high_d   = high_q;
    pos_d    = pos_q;
    stored_d = stored_q;
    if (acc_i) begin
      if (last_i) begin
        low_d    = '0;
        high_d   = '0;
        pos_d    = '0;
        stored_d = '0;
      end else begin
        low_d    = low_nxt;
        high_d   = high_nxt;
        stored_d = stored_nxt;
        pos_d    = (pos_q == fl64_pkg::PosW'(fl64_pkg::MaxWords - 1)) ?
                   '0 : pos_q + fl64_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= '0;
      high_q   <= '0;
      pos_q    <= '0;
      stored_q <= '0;
    end else begin
      low_q    <= low_d;
      high_q   <= high_d;
      pos_q    <= pos_d;
      stored_q <= stored_d;
    end
  end

  a_clear_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && last_i |=> pos_q == '0 && low_q == '0 && high_q == '0 && stored_q == '0)
    else $error("range state not cleared after last word");

  a_hold_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc_i |=> $stable(pos_q) && $stable(low_q) && $stable(high_q))
    else $error("sums moved without an accepted word");

  a_insert_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && cfg_i.insert_mode |-> res_o.match)
    else $error("insert mode result without match");

endmodule

[bench/tb_fletcher64_word_checksum.sv]
// Self-checking testbench for fletcher64_word_checksum: random word ranges against a predictor.
`timescale 1ns / 100ps

module tb_fletcher64_word_checksum;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseWords = 250;
  localparam int unsigned MaxShown   = 40;

  // Predicts checksum results and holds the ones still due from the block.
  class checksum_board;
    logic [fl64_pkg::IdxW-1:0]  cks_index;
    logic                       ins_mode;
    logic [fl64_pkg::WordW-1:0] lo_sum;
    logic [fl64_pkg::WordW-1:0] hi_sum;
    logic [fl64_pkg::PosW-1:0]  pos;
    logic [fl64_pkg::CsumW-1:0] stored;
    fl64_pkg::res_t             due[$];
    int unsigned                errors;

    function new();
      cks_index = '0;
      ins_mode  = 1'b0;
      errors    = 0;
      clear_range();
    endfunction

    function void clear_range();
      lo_sum = '0;
      hi_sum = '0;
      pos    = '0;
      stored = '0;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    task report(input string msg);
      if (errors < MaxShown) $display("ERROR %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_word(input logic [fl64_pkg::WordW-1:0] w, input logic l);
      logic [fl64_pkg::IdxW:0]    second;
      logic [fl64_pkg::CsumW-1:0] csum;
      fl64_pkg::res_t             r;
      // second slot compared at 17 bits: never hit when index is all ones
      second = {1'b0, cks_index} + 1'b1;
      if (pos == cks_index) begin
        stored[fl64_pkg::WordW-1:0] = w;
        hi_sum += lo_sum;
      end else if ({1'b0, pos} == second) begin
        stored[fl64_pkg::CsumW-1:fl64_pkg::WordW] = w;
        hi_sum += lo_sum;
      end else begin
        lo_sum += w;
        hi_sum += lo_sum;
      end
      pos = pos + 1'b1;
      if (l) begin
        csum = {hi_sum, lo_sum};
        r.checksum_value = csum;
        r.match = ins_mode ? 1'b1 : (stored == csum);
        due.push_back(r);
        clear_range();
      end
    endfunction

    task check_result(input logic [fl64_pkg::CsumW-1:0] v, input logic m);
      fl64_pkg::res_t e;
      if (due.size() == 0) begin
        report($sformatf("unexpected checksum %h match %b", v, m));
      end else begin
        e = due.pop_front();
        if (v !== e.checksum_value)
          report($sformatf("checksum %h, want %h", v, e.checksum_value));
        if (m !== e.match)
          report($sformatf("match %b, want %b (checksum %h)", m, e.match, e.checksum_value));
      end
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [fl64_pkg::CfgAddrW-1:0] cfg_index_i;
  logic [fl64_pkg::CfgDataW-1:0] cfg_wdata_i;

  fl64_word_if word_ch ();
  fl64_csum_if csum_ch ();

  fletcher64_word_checksum dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (word_ch),
    .csum_o      (csum_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  checksum_board board;
  bit            calm;
  bit            hold_go;
  int unsigned   stall;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    board               = new();
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_index_i         = fl64_pkg::CFG_CHECKSUM_INDEX;
    cfg_wdata_i         = '0;
    word_ch.valid       = 1'b0;
    word_ch.data_word   = '0;
    word_ch.last_word   = 1'b0;
    csum_ch.ready       = 1'b0;
    calm                = 1'b0;
    hold_go             = 1'b0;
    stall               = 0;
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_go) begin
      csum_ch.ready <= 1'b0;
      repeat (HoldCycles) @(posedge clk_i);
      hold_go = 1'b0;
    end else begin
      csum_ch.ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && csum_ch.valid && csum_ch.ready)
      board.check_result(csum_ch.checksum_value, csum_ch.match);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((word_ch.valid && word_ch.ready) || (csum_ch.valid && csum_ch.ready)) begin
        stall = 0;
      end else begin
        stall++;
        if (stall >= StallLimit) begin
          $display("tb_fletcher64_word_checksum: done, errors");
          $finish;
        end
      end
    end
  end

  function automatic logic [fl64_pkg::WordW-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [fl64_pkg::IdxW-1:0] pick_index();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 16'hFFFE;
      2:       return 16'hFFFF;
      3:       return fl64_pkg::IdxW'($urandom_range(65535));
      default: return fl64_pkg::IdxW'($urandom_range(24));
    endcase
  endfunction

  // checksum of a fresh range; the slot words do not affect it
  function automatic logic [fl64_pkg::CsumW-1:0] range_csum(
      input logic [fl64_pkg::WordW-1:0] ws[$], input logic [fl64_pkg::IdxW-1:0] idx);
    logic [fl64_pkg::WordW-1:0] lo;
    logic [fl64_pkg::WordW-1:0] hi;
    lo = '0;
    hi = '0;
    foreach (ws[k]) begin
      if (k != int'(idx) && k != int'(idx) + 1) lo += ws[k];
      hi += lo;
    end
    return {hi, lo};
  endfunction

  task automatic send_word(input logic [fl64_pkg::WordW-1:0] w, input logic l);
    if (!calm && $urandom_range(99) < 7) begin
      word_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    word_ch.valid     <= 1'b1;
    word_ch.data_word <= w;
    word_ch.last_word <= l;
    do @(posedge clk_i); while (word_ch.ready !== 1'b1);
    board.note_word(w, l);
  endtask

  // seal: put the correct checksum into the slots; spoil: flip one bit afterwards
  task automatic send_range(input int unsigned len, input bit seal, input bit spoil);
    logic [fl64_pkg::WordW-1:0] ws[$];
    logic [fl64_pkg::CsumW-1:0] c;
    int unsigned                idx;
    int unsigned                b;
    ws = {};
    repeat (len) ws.push_back(pick_word());
    idx = board.cks_index;
    if (seal) begin
      c = range_csum(ws, board.cks_index);
      if (idx < len) ws[idx] = c[fl64_pkg::WordW-1:0];
      if (idx + 1 < len) ws[idx+1] = c[fl64_pkg::CsumW-1:fl64_pkg::WordW];
    end
    if (spoil) begin
      b = $urandom_range(len * fl64_pkg::WordW - 1);
      ws[b / fl64_pkg::WordW][b % fl64_pkg::WordW] =
        ~ws[b / fl64_pkg::WordW][b % fl64_pkg::WordW];
    end
    foreach (ws[k]) send_word(ws[k], k == len - 1);
  endtask

  // stop offering words and wait out every pending checksum
  task automatic drain();
    word_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [fl64_pkg::IdxW-1:0] idx, input logic mode);
    logic [fl64_pkg::CfgDataW-1:0] mode_data;
    mode_data = fl64_pkg::CfgDataW'($urandom);
    mode_data[0] = mode;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= fl64_pkg::CFG_CHECKSUM_INDEX;
    cfg_wdata_i <= idx;
    @(posedge clk_i);
    board.cks_index = idx;
    cfg_index_i <= fl64_pkg::CFG_INSERT_MODE;
    cfg_wdata_i <= mode_data;
    @(posedge clk_i);
    board.ins_mode = mode;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    bit          seal;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: slot at word 0, verify
    send_word('1, 1'b1);
    send_word('0, 1'b1);
    send_range(4, 1'b1, 1'b0);
    drain();
    write_regs(16'd2, 1'b0);
    send_range(3, 1'b1, 1'b0);
    drain();
    // checksum field never reached
    write_regs(16'hFFFE, 1'b1);
    send_word('1, 1'b0);
    send_word('0, 1'b0);
    send_word('1, 1'b1);
    drain();
    // registers change in the middle of a range
    write_regs(16'd1, 1'b0);
    repeat (5) send_word(pick_word(), 1'b0);
    drain();
    write_regs(16'd0, 1'b1);
    send_word(pick_word(), 1'b0);
    send_word(pick_word(), 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_regs(pick_index(), ph == 0 ? 1'b1 : (ph == 1 ? 1'b0 : 1'($urandom_range(1))));
      calm = (ph == 2);
      if (ph == 4) hold_go = 1'b1;
      sent = 0;
      while (sent < PhaseWords) begin
        len  = ($urandom_range(9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        seal = $urandom_range(9) < 6;
        send_range(len, seal, seal && $urandom_range(9) < 3);
        sent += len;
      end
      drain();
    end
    calm = 1'b0;

    repeat (8) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_fletcher64_word_checksum: done, clean");
    end else begin
      $display("tb_fletcher64_word_checksum: done, errors");
    end
    $finish;
  end

endmodule
